// ===== rtl/dpt_pkg.sv =====
package dpt_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned CW = 7;
  localparam int unsigned NSP = 12;
  localparam int unsigned NWIT = 7;
  localparam int unsigned SPW = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMALL,
    S_SPLIT,
    S_WIT,
    S_POW_MUL,
    S_POW_SQ,
    S_CHECK,
    S_SQR,
    S_SQR_CHK,
    S_DONE
  } state_e;

  function automatic logic [SPW-1:0] small_prime(input logic [3:0] idx);
    logic [SPW-1:0] p;
    case (idx)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      default: p = 6'd2;
    endcase
    return p;
  endfunction

  function automatic logic [30:0] witness(input logic [2:0] idx);
    logic [30:0] w;
    case (idx)
      3'd0: w = 31'd2;
      3'd1: w = 31'd325;
      3'd2: w = 31'd9375;
      3'd3: w = 31'd28178;
      3'd4: w = 31'd450775;
      3'd5: w = 31'd9780504;
      3'd6: w = 31'd1795265022;
      default: w = 31'd2;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/dpt_smallmod.sv =====
module dpt_smallmod import dpt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [W-1:0]   number_i,
  input  logic [SPW-1:0] divisor_i,
  output logic           done_o,
  output logic           zero_o
);

  logic [W-1:0]   sh_q, sh_d;
  logic [SPW:0]   rem_q, rem_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           run_q, run_d;
  logic [SPW+1:0] trial;

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    trial = {rem_q[SPW:0], sh_q[W-1]};
    if (start_i) begin
      sh_d  = number_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      sh_d = {sh_q[W-2:0], 1'b0};
      if (trial >= {2'b00, divisor_i}) begin
        rem_d = (SPW+1)'(trial - {2'b00, divisor_i});
      end else begin
        rem_d = trial[SPW:0];
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = run_q && (cnt_q == CW'(W - 1));
  assign zero_o = (rem_d == '0);

endmodule

// ===== rtl/dpt_mulmod.sv =====
module dpt_mulmod import dpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] m_i,
  output logic         done_o,
  output logic [W-1:0] p_o
);

  logic [W-1:0]  x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic          run_q, run_d;
  logic [W-1:0]  gap_a, gap_x;

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    acc_d = acc_q;
    run_d = run_q;
    gap_a = m_i - x_q;
    gap_x = m_i - x_q;
    if (start_i) begin
      x_d   = x_i;
      y_d   = y_i;
      acc_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (y_q == '0) begin
        run_d = 1'b0;
      end else begin
        if (y_q[0]) begin
          acc_d = (acc_q >= gap_a) ? acc_q - gap_a : acc_q + x_q;
        end
        x_d = (x_q >= gap_x) ? x_q - gap_x : x_q + x_q;
        y_d = {1'b0, y_q[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  assign done_o = run_q && (y_q == '0);
  assign p_o    = acc_q;

endmodule

// ===== rtl/deterministic_primality_test_u64.sv =====
// Channel  Ports                    Dir  Handshake
// input    start_i, number_i        in   taken when start_i && !busy_o
// result   valid_o, is_prime_o      out  one-cycle strobe, no stall
//
// Sequence: a bit-serial remainder per small prime (12 primes), then per
// witness one reduction and up to 125 bit-serial modular products.
// The shift-and-add multiplier-reducer dominates the run time.
// Reset clears the controller; busy_o is low after reset.
module deterministic_primality_test_u64 import dpt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] number_i,
  output logic         busy_o,
  output logic         valid_o,
  output logic         is_prime_o
);

  state_e        state_q, state_d;
  logic [W-1:0]  n_q, n_d, d_q, d_d, e_q, e_d, acc_q, acc_d, sq_q, sq_d;
  logic [CW-1:0] s_q, s_d, k_q, k_d;
  logic [3:0]    sp_q, sp_d;
  logic [2:0]    wi_q, wi_d;
  logic          res_q, res_d, vld_q, vld_d, sm_go_q, sm_go_d;
  logic          wit_red_q, wit_red_d;
  logic          sqr_q, sqr_d;
  logic          sm_done, sm_zero;
  logic [W-1:0]  mx, my, mp, nm1;
  logic          m_start, m_done;

  assign nm1 = n_q - 64'd1;

  dpt_smallmod u_sm (
    .clk_i, .rst_ni, .start_i(sm_go_q),
    .number_i(n_q), .divisor_i(small_prime(sp_q)),
    .done_o(sm_done), .zero_o(sm_zero)
  );

  dpt_mulmod u_mm (
    .clk_i, .rst_ni, .start_i(m_start), .x_i(mx), .y_i(my), .m_i(n_q),
    .done_o(m_done), .p_o(mp)
  );

  always_comb begin
    state_d   = state_q;
    n_d = n_q; d_d = d_q; e_d = e_q; acc_d = acc_q; sq_d = sq_q;
    s_d = s_q; k_d = k_q; sp_d = sp_q; wi_d = wi_q; sqr_d = sqr_q;
    res_d = res_q; vld_d = 1'b0; sm_go_d = 1'b0; wit_red_d = wit_red_q;
    m_start = 1'b0;
    mx = acc_q;
    my = sq_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d = number_i;
          sp_d = '0;
          if (number_i < 64'd2) begin
            res_d = 1'b0; state_d = S_DONE;
          end else begin
            sm_go_d = 1'b1; state_d = S_SMALL;
          end
        end
      end
      S_SMALL: begin
        if (sm_done) begin
          if (n_q == W'(small_prime(sp_q))) begin
            res_d = 1'b1; state_d = S_DONE;
          end else if (sm_zero) begin
            res_d = 1'b0; state_d = S_DONE;
          end else if (sp_q == 4'(NSP - 1)) begin
            d_d = nm1; s_d = '0; state_d = S_SPLIT;
          end else begin
            sp_d = sp_q + 4'd1; sm_go_d = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[W-1:1]}; s_d = s_q + CW'(1);
        end else begin
          wi_d = '0; state_d = S_WIT; wit_red_d = 1'b1;
        end
      end
      S_WIT: begin
        // reduce base mod n as 1*base mod n
        if (wit_red_q) begin
          mx = 64'd1; my = W'(witness(wi_q));
          m_start = 1'b1; wit_red_d = 1'b0;
        end else if (m_done) begin
          if (mp == '0) begin
            if (wi_q == 3'(NWIT - 1)) begin
              res_d = 1'b1; state_d = S_DONE;
            end else begin
              wi_d = wi_q + 3'd1; wit_red_d = 1'b1;
            end
          end else begin
            sq_d = mp; acc_d = 64'd1; e_d = d_q; state_d = S_POW_MUL;
          end
        end
      end
      S_POW_MUL: begin
        if (e_q == '0) begin
          state_d = S_CHECK;
        end else if (e_q[0]) begin
          mx = acc_q; my = sq_q; m_start = 1'b1; state_d = S_POW_SQ;
          e_d = {e_q[W-1:1], 1'b0}; sqr_d = 1'b0;
        end else begin
          mx = sq_q; my = sq_q; m_start = 1'b1; state_d = S_POW_SQ;
          e_d = {1'b0, e_q[W-1:1]}; sqr_d = 1'b1;
        end
      end
      S_POW_SQ: begin
        if (m_done) begin
          state_d = S_POW_MUL;
          if (sqr_q) begin
            sq_d = mp;
          end else begin
            acc_d = mp;
          end
        end
      end
      S_CHECK: begin
        if (acc_q == 64'd1 || acc_q == nm1) begin
          if (wi_q == 3'(NWIT - 1)) begin
            res_d = 1'b1; state_d = S_DONE;
          end else begin
            wi_d = wi_q + 3'd1; wit_red_d = 1'b1; state_d = S_WIT;
          end
        end else begin
          k_d = CW'(1); state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (k_q >= s_q) begin
          res_d = 1'b0; state_d = S_DONE;
        end else begin
          mx = acc_q; my = acc_q; m_start = 1'b1; state_d = S_SQR_CHK;
        end
      end
      S_SQR_CHK: begin
        if (m_done) begin
          acc_d = mp;
          if (mp == nm1) begin
            if (wi_q == 3'(NWIT - 1)) begin
              res_d = 1'b1; state_d = S_DONE;
            end else begin
              wi_d = wi_q + 3'd1; wit_red_d = 1'b1; state_d = S_WIT;
            end
          end else begin
            k_d = k_q + CW'(1); state_d = S_SQR;
          end
        end
      end
      S_DONE: begin
        vld_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= 1'b0;
      sm_go_q   <= 1'b0;
      wit_red_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      sm_go_q   <= sm_go_d;
      wit_red_q <= wit_red_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; acc_q <= acc_d; sq_q <= sq_d;
    s_q <= s_d; k_q <= k_d; sp_q <= sp_d; wi_q <= wi_d; res_q <= res_d;
    sqr_q <= sqr_d;
  end

  assign busy_o     = (state_q != S_IDLE);
  assign valid_o    = vld_q;
  assign is_prime_o = res_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> state_q == S_IDLE) else $error("result outside idle");
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_start |-> state_q != S_IDLE) else $error("multiply while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> valid_o) else $error("result not strobed");

endmodule
